// ===== hdl/evp_pkg.sv =====
// Shared constants, types and register codes of the ellipse polygon vertex generator.
package evp_pkg;

	localparam int MAX_POINTS     = 1024;
	localparam int DEFAULT_POINTS = 64;

	localparam int IDX_W    = 11;
	localparam int COORD_W  = 24;
	localparam int RAD_W    = 23;
	localparam int TILT_W   = 9;
	localparam int CNT_W    = 11;
	localparam int CFG_IDX_W = 3;

	// Degrees in a full turn and the rounding term of the tilt conversion.
	localparam logic [8:0] TILT_TURN  = 9'd360;
	localparam logic [9:0] TILT_ROUND = 10'd180;

	// 2^32 = 360 * THETA_STEP + 256; THETA_RCP = ceil(2^26 / 360) is exact for
	// dividends below 2^17.
	localparam logic [31:0] THETA_STEP = 32'd11930464;
	localparam logic [17:0] THETA_RCP  = 18'd186414;

	// Request queue between the front and back parts.
	localparam int QDEPTH = 4;
	localparam int QPTR_W = 2;

	// Restoring divider: 32 quotient bits, four per stage.
	localparam int DIV_STAGES = 8;
	localparam int DIV_BITS   = 4;

	// Trig pipeline: two stages of setup, three per Horner step, two to finish.
	localparam int TRIG_STEPS = 4;
	localparam int TRIG_LAT   = 2 + 3 * TRIG_STEPS + 2;
	localparam int ROT_LAT    = 5;
	localparam int PIPE_LAT   = DIV_STAGES + TRIG_LAT + ROT_LAT;

	localparam logic [30:0] Q30_ONE     = 31'h4000_0000;
	localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;

	// Horner divisors, innermost term first, and their 2^32 reciprocals.
	localparam logic [6:0] SIN_DIV [TRIG_STEPS] = '{7'd72, 7'd42, 7'd20, 7'd6};
	localparam logic [6:0] COS_DIV [TRIG_STEPS] = '{7'd90, 7'd56, 7'd30, 7'd12};
	localparam logic [31:0] SIN_RCP [TRIG_STEPS] = '{
		32'(64'h1_0000_0000 / 72), 32'(64'h1_0000_0000 / 42),
		32'(64'h1_0000_0000 / 20), 32'(64'h1_0000_0000 / 6)};
	localparam logic [31:0] COS_RCP [TRIG_STEPS] = '{
		32'(64'h1_0000_0000 / 90), 32'(64'h1_0000_0000 / 56),
		32'(64'h1_0000_0000 / 30), 32'(64'h1_0000_0000 / 12)};

	localparam logic signed [26:0] SUM_MAX = 27'sd8388607;
	localparam logic signed [26:0] SUM_MIN = -27'sd8388608;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CENTER_X,
		REG_CENTER_Y,
		REG_RADIUS_FIRST,
		REG_RADIUS_SECOND,
		REG_TILT_DEGREES,
		REG_POINT_COUNT
	} evp_reg_t;

	// One classified request as it waits in the queue.
	typedef struct packed {
		logic [IDX_W-1:0] num_hi;
		logic [9:0]       num_lo;
		logic [CNT_W-1:0] divisor;
		logic             closing;
		logic             beyond;
	} evp_req_t;

	// Geometry registers seen by the back part.
	typedef struct packed {
		logic signed [COORD_W-1:0] center_x;
		logic signed [COORD_W-1:0] center_y;
		logic [RAD_W-1:0]          radius_first;
		logic [RAD_W-1:0]          radius_second;
		logic [TILT_W-1:0]         tilt_degrees;
	} evp_cfg_t;

endpackage

// ===== hdl/evp_front.sv =====
// Front part: classifies vertex requests and queues them for the back part.
module evp_front import evp_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_axis_tvalid,
	output logic             s_axis_tready,
	input  logic [15:0]      s_axis_tdata,
	input  logic [CNT_W-1:0] point_count,
	output evp_req_t         head,
	output logic             head_valid,
	input  logic             pop
);

	logic [IDX_W-1:0] idx;
	logic [CNT_W-1:0] n_eff;
	evp_req_t         req_new;
	logic             push;

	evp_req_t          mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;

	always_comb begin
		idx = s_axis_tdata[IDX_W-1:0];
		if (point_count == '0) begin
			n_eff = CNT_W'(DEFAULT_POINTS);
		end else if (point_count > CNT_W'(MAX_POINTS)) begin
			n_eff = CNT_W'(MAX_POINTS);
		end else begin
			n_eff = point_count;
		end
		req_new.closing = (idx == n_eff);
		req_new.beyond  = (idx > n_eff);
		// The closing vertex is vertex 0: a zero dividend gives a zero angle.
		req_new.num_hi  = req_new.closing ? '0 : idx;
		req_new.num_lo  = req_new.closing ? '0 : n_eff[CNT_W-1:1];
		req_new.divisor = n_eff;
	end

	assign s_axis_tready = (count_q != (QPTR_W+1)'(QDEPTH));
	assign push          = s_axis_tvalid && s_axis_tready;
	assign head          = mem_q[rd_ptr_q];
	assign head_valid    = (count_q != '0);

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= req_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== hdl/evp_div.sv =====
// Pipelined restoring divider that turns an index ratio into a turn fraction.
module evp_div import evp_pkg::*; (
	input  logic             clk,
	input  logic             en,
	input  logic [IDX_W-1:0] num_hi,
	input  logic [9:0]       num_lo,
	input  logic [CNT_W-1:0] divisor,
	output logic [31:0]      quot
);

	logic [CNT_W-1:0] rem_in [DIV_STAGES+1];
	logic [31:0]      num_in [DIV_STAGES+1];
	logic [CNT_W-1:0] div_in [DIV_STAGES+1];

	assign rem_in[0] = num_hi;
	assign num_in[0] = {22'd0, num_lo};
	assign div_in[0] = divisor;

	genvar j;
	generate
		for (j = 0; j < DIV_STAGES; j++) begin : g_stage
			logic [CNT_W-1:0] rem_c;
			logic [31:0]      num_c;
			logic [CNT_W:0]   trial;
			logic [CNT_W-1:0] rem_sd;
			logic [31:0]      num_sd;
			logic [CNT_W-1:0] div_sd;

			// Low dividend bits leave at the top while quotient bits enter at the bottom.
			always_comb begin
				rem_c = rem_in[j];
				num_c = num_in[j];
				trial = '0;
				for (int b = 0; b < DIV_BITS; b++) begin
					trial = {rem_c, num_c[31]};
					if (trial >= {1'b0, div_in[j]}) begin
						trial = trial - {1'b0, div_in[j]};
						num_c = {num_c[30:0], 1'b1};
					end else begin
						num_c = {num_c[30:0], 1'b0};
					end
					rem_c = trial[CNT_W-1:0];
				end
			end

			always_ff @(posedge clk) begin
				if (en) begin
					rem_sd <= rem_c;
					num_sd <= num_c;
					div_sd <= div_in[j];
				end
			end

			assign rem_in[j+1] = rem_sd;
			assign num_in[j+1] = num_sd;
			assign div_in[j+1] = div_sd;
		end
	endgenerate

	assign quot = num_in[DIV_STAGES];

endmodule

// ===== hdl/evp_trig.sv =====
// Pipelined cosine and sine of a turn fraction, Q30 results.
module evp_trig import evp_pkg::*; (
	input  logic               clk,
	input  logic               en,
	input  logic [31:0]        angle,
	output logic signed [31:0] cos_val,
	output logic signed [31:0] sin_val
);

	function automatic logic [30:0] rnd30(input logic [62:0] v);
		logic [62:0] s;
		s = v + 63'h2000_0000;
		return s[60:30];
	endfunction

	// Exact floor(p / c) from a reciprocal product and one correction.
	function automatic logic [30:0] corr_div(input logic [30:0] p, input logic [62:0] m,
			input logic [6:0] c);
		logic [30:0] q0;
		logic [37:0] qc;
		logic [30:0] r;
		q0 = m[62:32];
		qc = {7'd0, q0} * {31'd0, c};
		r  = p - qc[30:0];
		return (r >= {24'd0, c}) ? q0 + 31'd1 : q0;
	endfunction

	logic [29:0] r_in;
	logic [29:0] rr_in;
	logic        swap_in;
	logic [1:0]  quad_s1, quad_s2;
	logic        swap_s1, swap_s2;
	logic [29:0] x_s1, x_s2, x2_s2;

	// Fold into the first octant; the swap exchanges sine and cosine at the end.
	always_comb begin
		r_in    = angle[29:0];
		swap_in = (r_in > 30'h2000_0000);
		rr_in   = swap_in ? 30'(31'h4000_0000 - {1'b0, r_in}) : r_in;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			quad_s1 <= angle[31:30];
			swap_s1 <= swap_in;
			x_s1    <= 30'(rnd30(63'(rr_in) * 63'(HALF_PI_Q30)));
			quad_s2 <= quad_s1;
			swap_s2 <= swap_s1;
			x_s2    <= x_s1;
			x2_s2   <= 30'(rnd30(63'(x_s1) * 63'(x_s1)));
		end
	end

	logic [30:0] ts_in [TRIG_STEPS+1];
	logic [30:0] tc_in [TRIG_STEPS+1];
	logic [29:0] x_in  [TRIG_STEPS+1];
	logic [29:0] x2_in [TRIG_STEPS+1];
	logic [2:0]  qs_in [TRIG_STEPS+1];

	// With t = 1.0 the first step reduces to 1 - x2/c, so all steps look alike.
	assign ts_in[0] = Q30_ONE;
	assign tc_in[0] = Q30_ONE;
	assign x_in[0]  = x_s2;
	assign x2_in[0] = x2_s2;
	assign qs_in[0] = {quad_s2, swap_s2};

	genvar k;
	generate
		for (k = 0; k < TRIG_STEPS; k++) begin : g_step
			logic [30:0] ps_sa, pc_sa, ps_sb, pc_sb, ts_sc, tc_sc;
			logic [62:0] ms_sb, mc_sb;
			logic [29:0] x_sa, x2_sa, x_sb, x2_sb, x_sc, x2_sc;
			logic [2:0]  qs_sa, qs_sb, qs_sc;

			always_ff @(posedge clk) begin
				if (en) begin
					ps_sa <= rnd30(63'(x2_in[k]) * 63'(ts_in[k]));
					pc_sa <= rnd30(63'(x2_in[k]) * 63'(tc_in[k]));
					x_sa  <= x_in[k];
					x2_sa <= x2_in[k];
					qs_sa <= qs_in[k];

					ps_sb <= ps_sa;
					pc_sb <= pc_sa;
					ms_sb <= 63'(ps_sa) * 63'(SIN_RCP[k]);
					mc_sb <= 63'(pc_sa) * 63'(COS_RCP[k]);
					x_sb  <= x_sa;
					x2_sb <= x2_sa;
					qs_sb <= qs_sa;

					ts_sc <= Q30_ONE - corr_div(ps_sb, ms_sb, SIN_DIV[k]);
					tc_sc <= Q30_ONE - corr_div(pc_sb, mc_sb, COS_DIV[k]);
					x_sc  <= x_sb;
					x2_sc <= x2_sb;
					qs_sc <= qs_sb;
				end
			end

			assign ts_in[k+1] = ts_sc;
			assign tc_in[k+1] = tc_sc;
			assign x_in[k+1]  = x_sc;
			assign x2_in[k+1] = x2_sc;
			assign qs_in[k+1] = qs_sc;
		end
	endgenerate

	logic [30:0]        s0_f1, c0_f1;
	logic [2:0]         qs_f1;
	logic signed [31:0] cs, sn, co_c, si_c;

	always_ff @(posedge clk) begin
		if (en) begin
			s0_f1 <= rnd30(63'(x_in[TRIG_STEPS]) * 63'(ts_in[TRIG_STEPS]));
			c0_f1 <= Q30_ONE - (rnd30(63'(x2_in[TRIG_STEPS]) * 63'(tc_in[TRIG_STEPS])) >> 1);
			qs_f1 <= qs_in[TRIG_STEPS];
		end
	end

	always_comb begin
		if (qs_f1[0]) begin
			cs = $signed({1'b0, s0_f1});
			sn = $signed({1'b0, c0_f1});
		end else begin
			cs = $signed({1'b0, c0_f1});
			sn = $signed({1'b0, s0_f1});
		end
		unique case (qs_f1[2:1])
			2'd0: begin
				co_c = cs;
				si_c = sn;
			end
			2'd1: begin
				co_c = -sn;
				si_c = cs;
			end
			2'd2: begin
				co_c = -cs;
				si_c = -sn;
			end
			default: begin
				co_c = sn;
				si_c = -cs;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cos_val <= co_c;
			sin_val <= si_c;
		end
	end

endmodule

// ===== hdl/evp_back.sv =====
// Back part: angle division, trig, scaling, rotation and the result register.
module evp_back import evp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  evp_req_t    req,
	input  logic        req_valid,
	output logic        req_pop,
	input  evp_cfg_t    cfg,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [47:0] m_axis_tdata,
	output logic        m_axis_tlast,
	output logic        m_axis_tuser
);

	logic        adv;
	logic        out_valid_q;
	logic [8:0]  tilt_mod;
	logic [16:0] tilt_rem;
	logic [34:0] tilt_frac;
	logic [31:0] theta_c;
	logic [31:0] phi, theta_q;
	logic signed [31:0] cp, sp, ct, st;

	// Whole pipeline moves together; it freezes only while a result waits.
	assign adv     = !out_valid_q || m_axis_tready;
	assign req_pop = adv && req_valid;

	assign tilt_mod = (cfg.tilt_degrees >= TILT_TURN) ? cfg.tilt_degrees - TILT_TURN
		: cfg.tilt_degrees;

	// The tilt angle is t * THETA_STEP plus floor((256 t + 180) / 360); the small
	// quotient comes from a reciprocal product. It only follows the register.
	assign tilt_rem  = {tilt_mod, 8'd0} + 17'(TILT_ROUND);
	assign tilt_frac = 35'(tilt_rem) * 35'(THETA_RCP);
	assign theta_c   = 32'(tilt_mod) * THETA_STEP + 32'(tilt_frac[34:26]);

	always_ff @(posedge clk) begin
		theta_q <= theta_c;
	end

	evp_div u_div_phi (
		.clk     (clk),
		.en      (adv),
		.num_hi  (req.num_hi),
		.num_lo  (req.num_lo),
		.divisor (req.divisor),
		.quot    (phi)
	);

	evp_trig u_trig_phi (
		.clk     (clk),
		.en      (adv),
		.angle   (phi),
		.cos_val (cp),
		.sin_val (sp)
	);

	evp_trig u_trig_theta (
		.clk     (clk),
		.en      (adv),
		.angle   (theta_q),
		.cos_val (ct),
		.sin_val (st)
	);

	logic signed [55:0] dxp_s1, dyp_s1, rdx, rdy;
	logic signed [30:0] dx_s2, dy_s2;
	logic signed [31:0] ct_s1, st_s1, ct_s2, st_s2;
	logic signed [62:0] pxc_s3, pys_s3, pxs_s3, pyc_s3;
	logic signed [63:0] sx_s4, sy_s4, rsx, rsy;
	logic signed [25:0] ox_s5, oy_s5;
	logic signed [26:0] sum_x, sum_y;
	logic [23:0]        px, py;

	always_comb begin
		rdx = dxp_s1 + (dxp_s1[55] ? 56'sh7F_FFFF : 56'sh80_0000);
		rdy = dyp_s1 + (dyp_s1[55] ? 56'sh7F_FFFF : 56'sh80_0000);
		rsx = sx_s4 + (sx_s4[63] ? 64'sh7_FFFF_FFFF : 64'sh8_0000_0000);
		rsy = sy_s4 + (sy_s4[63] ? 64'sh7_FFFF_FFFF : 64'sh8_0000_0000);
		sum_x = 27'(cfg.center_x) + 27'(ox_s5);
		sum_y = 27'(cfg.center_y) + 27'(oy_s5);
		if (sum_x > SUM_MAX) begin
			px = SUM_MAX[23:0];
		end else if (sum_x < SUM_MIN) begin
			px = SUM_MIN[23:0];
		end else begin
			px = sum_x[23:0];
		end
		if (sum_y > SUM_MAX) begin
			py = SUM_MAX[23:0];
		end else if (sum_y < SUM_MIN) begin
			py = SUM_MIN[23:0];
		end else begin
			py = sum_y[23:0];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dxp_s1 <= $signed({1'b0, cfg.radius_first}) * cp;
			dyp_s1 <= $signed({1'b0, cfg.radius_second}) * sp;
			ct_s1  <= ct;
			st_s1  <= st;
			dx_s2  <= rdx[54:24];
			dy_s2  <= rdy[54:24];
			ct_s2  <= ct_s1;
			st_s2  <= st_s1;
			pxc_s3 <= dx_s2 * ct_s2;
			pys_s3 <= dy_s2 * st_s2;
			pxs_s3 <= dx_s2 * st_s2;
			pyc_s3 <= dy_s2 * ct_s2;
			sx_s4  <= pxc_s3 - pys_s3;
			sy_s4  <= pxs_s3 + pyc_s3;
			ox_s5  <= rsx[61:36];
			oy_s5  <= rsy[61:36];
		end
	end

	logic [PIPE_LAT-1:0] vld_q, closing_q, beyond_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q       <= '0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			vld_q       <= {vld_q[PIPE_LAT-2:0], req_valid};
			out_valid_q <= vld_q[PIPE_LAT-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			closing_q    <= {closing_q[PIPE_LAT-2:0], req.closing};
			beyond_q     <= {beyond_q[PIPE_LAT-2:0], req.beyond};
			m_axis_tdata <= beyond_q[PIPE_LAT-1] ? 48'd0 : {py, px};
			m_axis_tlast <= closing_q[PIPE_LAT-1];
			m_axis_tuser <= beyond_q[PIPE_LAT-1];
		end
	end

	assign m_axis_tvalid = out_valid_q;

endmodule

// ===== hdl/ellipse_polygon_vertex.sv =====
// Top level of the tilted-ellipse polygon vertex generator.
//
//  Channel      | Direction | Payload
//  -------------+-----------+------------------------------------------------------
//  s_axis       | in        | tdata[10:0] vertex_index
//  m_axis       | out       | tdata[23:0] point_x, [47:24] point_y; tlast closing_vertex;
//               |           | tuser index_beyond
//  cfg          | in        | cfg_wr_en, cfg_index (register number), cfg_data
//
// A request is taken every cycle while the four-entry queue has room; results leave
// at one per cycle while the output is ready. The back part is a 29-stage pipeline
// (eight divider stages of four quotient bits, sixteen trig stages, five scale and
// rotate stages) plus the result register. Reset clears the configuration to zero
// and empties the queue and pipeline; no clearing pass follows. While a result waits,
// the back pipeline holds and the queue keeps taking requests until it is full.
module ellipse_polygon_vertex import evp_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	input  logic [15:0]          s_axis_tdata,   // [10:0] vertex_index
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	output logic [47:0]          m_axis_tdata,   // [23:0] point_x, [47:24] point_y
	output logic                 m_axis_tlast,
	output logic                 m_axis_tuser,   // [0] index_beyond
	input  logic                 cfg_wr_en,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [23:0]          cfg_data
);

	evp_cfg_t         cfg_q;
	logic [CNT_W-1:0] point_count_q;
	evp_req_t         head;
	logic             head_valid;
	logic             head_pop;

	// Register writes; indexes past the list are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q         <= '0;
			point_count_q <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_CENTER_X:      cfg_q.center_x      <= cfg_data;
				REG_CENTER_Y:      cfg_q.center_y      <= cfg_data;
				REG_RADIUS_FIRST:  cfg_q.radius_first  <= cfg_data[RAD_W-1:0];
				REG_RADIUS_SECOND: cfg_q.radius_second <= cfg_data[RAD_W-1:0];
				REG_TILT_DEGREES:  cfg_q.tilt_degrees  <= cfg_data[TILT_W-1:0];
				REG_POINT_COUNT:   point_count_q       <= cfg_data[CNT_W-1:0];
				default:           cfg_q               <= cfg_q;
			endcase
		end
	end

	// The front resolves the count and flags each request before it is queued.
	evp_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.point_count   (point_count_q),
		.head          (head),
		.head_valid    (head_valid),
		.pop           (head_pop)
	);

	// The back computes the vertex and holds the result until it is taken.
	evp_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.req           (head),
		.req_valid     (head_valid),
		.req_pop       (head_pop),
		.cfg           (cfg_q),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser)
	);

endmodule

// ===== tb/tb_ellipse_polygon_vertex.sv =====
// Self-checking testbench for the tilted-ellipse polygon vertex generator.
`timescale 1ns / 1ps

module tb_ellipse_polygon_vertex import evp_pkg::*; ();

	localparam longint CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 60;

	typedef struct {
		logic [23:0] px;
		logic [23:0] py;
		logic        closing;
		logic        beyond;
	} vertex_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [15:0] s_axis_tdata = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [47:0] m_axis_tdata;
	logic m_axis_tlast;
	logic m_axis_tuser;
	logic cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [23:0] cfg_data = '0;

	ellipse_polygon_vertex dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Shadow copy of the geometry registers used by the predictor.
	logic [23:0] sh_cx, sh_cy;
	logic [22:0] sh_a, sh_b;
	logic [8:0]  sh_tilt;
	logic [10:0] sh_n;

	logic [10:0] pending_idx[$];
	vertex_t     expected_vertices[$];
	int          mismatches = 0;
	longint      cycles = 0;
	bit          calm = 1'b0;      // no idling in the final stretch
	bit          hold_sender = 1'b0;
	int          long_stall = 0;

	function automatic logic [63:0] qmul(logic [63:0] p, logic [63:0] q);
		return (p * q + 64'd536870912) >> 30;
	endfunction

	function automatic longint rnd_shift(longint v, int sh);
		longint m;
		m = (v < 0) ? -v : v;
		m = (m + (64'sd1 <<< (sh - 1))) >>> sh;
		return (v < 0) ? -m : m;
	endfunction

	// Q30 cosine and sine of a 32-bit turn fraction.
	task automatic cos_sin(input logic [31:0] p, output longint co, output longint si);
		logic [63:0] r, rr, x, x2, t, s0, c0, k;
		logic [1:0] quad;
		bit swap;
		quad = p[31:30];
		r = {34'd0, p[29:0]};
		swap = r > 64'h2000_0000;
		rr = swap ? 64'h4000_0000 - r : r;
		x = (rr * 64'd1686629713 + 64'd536870912) >> 30;
		x2 = qmul(x, x);
		t = 64'h4000_0000 - x2 / 72;
		t = 64'h4000_0000 - qmul(x2, t) / 42;
		t = 64'h4000_0000 - qmul(x2, t) / 20;
		t = 64'h4000_0000 - qmul(x2, t) / 6;
		s0 = qmul(x, t);
		t = 64'h4000_0000 - x2 / 90;
		t = 64'h4000_0000 - qmul(x2, t) / 56;
		t = 64'h4000_0000 - qmul(x2, t) / 30;
		t = 64'h4000_0000 - qmul(x2, t) / 12;
		c0 = 64'h4000_0000 - qmul(x2, t) / 2;
		if (swap) begin
			k = s0; s0 = c0; c0 = k;
		end
		case (quad)
			2'd0: begin co = c0; si = s0; end
			2'd1: begin co = -longint'(s0); si = c0; end
			2'd2: begin co = -longint'(c0); si = -longint'(s0); end
			default: begin co = s0; si = -longint'(c0); end
		endcase
	endtask

	function automatic logic [23:0] clamp24(longint v);
		if (v > 8388607) return 24'h7FFFFF;
		if (v < -8388608) return 24'h800000;
		return v[23:0];
	endfunction

	task automatic predict_vertex(input logic [10:0] idx, output vertex_t v);
		logic [63:0] n, num;
		logic [31:0] phi, theta;
		longint cp, sp, ct, st, dx, dy;
		n = (sh_n == 0) ? DEFAULT_POINTS : sh_n;
		if (n > MAX_POINTS) n = MAX_POINTS;
		v = '{24'd0, 24'd0, 1'b0, 1'b0};
		if (idx > n) begin
			v.beyond = 1'b1;
			return;
		end
		num = ({53'd0, idx} << 32) + n / 2;
		phi = (idx == n) ? 32'd0 : 32'(num / n);
		theta = 32'((({55'd0, sh_tilt} << 32) + 180) / 360);
		cos_sin(phi, cp, sp);
		cos_sin(theta, ct, st);
		dx = rnd_shift(longint'(sh_a) * cp, 24);
		dy = rnd_shift(longint'(sh_b) * sp, 24);
		v.px = clamp24(longint'(signed'(sh_cx)) + rnd_shift(dx * ct - dy * st, 36));
		v.py = clamp24(longint'(signed'(sh_cy)) + rnd_shift(dx * st + dy * ct, 36));
		v.closing = (idx == n);
	endtask

	// Request driver: a request stays offered until the block takes it.
	int send_gap = 0;
	always @(posedge clk) begin
		vertex_t v;
		if (s_axis_tvalid && s_axis_tready) begin
			predict_vertex(s_axis_tdata[10:0], v);
			expected_vertices.push_back(v);
		end
		if (s_axis_tvalid && !s_axis_tready) begin
			// hold
		end else if (send_gap > 0) begin
			send_gap <= send_gap - 1;
			s_axis_tvalid <= 1'b0;
		end else if (!calm && $urandom_range(0, 9) == 0) begin
			send_gap <= $urandom_range(0, 4);
			s_axis_tvalid <= 1'b0;
		end else if (arst_n && !hold_sender && pending_idx.size() > 0) begin
			s_axis_tvalid <= 1'b1;
			s_axis_tdata <= {5'd0, pending_idx.pop_front()};
		end else begin
			s_axis_tvalid <= 1'b0;
		end
	end

	// Result monitor with random back-pressure and an occasional long hold-off.
	int recv_gap = 0;
	always @(posedge clk) begin
		vertex_t e;
		cycles <= cycles + 1;
		if (m_axis_tvalid && m_axis_tready) begin
			if (expected_vertices.size() == 0) begin
				mismatches <= mismatches + 1;
				if (mismatches < 10)
					$display("Unexpected result x=%h y=%h", m_axis_tdata[23:0],
						m_axis_tdata[47:24]);
			end else begin
				e = expected_vertices.pop_front();
				if (m_axis_tdata[23:0] !== e.px || m_axis_tdata[47:24] !== e.py ||
						m_axis_tlast !== e.closing || m_axis_tuser !== e.beyond) begin
					mismatches <= mismatches + 1;
					if (mismatches < 10)
						$display("Mismatch: expected x=%h y=%h c=%b b=%b, got x=%h y=%h c=%b b=%b",
							e.px, e.py, e.closing, e.beyond, m_axis_tdata[23:0],
							m_axis_tdata[47:24], m_axis_tlast, m_axis_tuser);
				end
			end
		end
		if (long_stall > 0) begin
			long_stall <= long_stall - 1;
			m_axis_tready <= 1'b0;
		end else if (recv_gap > 0) begin
			recv_gap <= recv_gap - 1;
			m_axis_tready <= 1'b0;
		end else if (!calm && $urandom_range(0, 7) == 0) begin
			recv_gap <= $urandom_range(0, 4);
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= arst_n;
		end
		if (cycles > CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	task automatic wait_idle();
		while (pending_idx.size() > 0 || s_axis_tvalid || expected_vertices.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Back-to-back register writes keep the enable high; the caller drops it.
	task automatic write_reg(input evp_reg_t r, input logic [23:0] val);
		cfg_wr_en <= 1'b1;
		cfg_index <= r;
		cfg_data <= val;
		@(posedge clk);
		case (r)
			REG_CENTER_X: sh_cx = val;
			REG_CENTER_Y: sh_cy = val;
			REG_RADIUS_FIRST: sh_a = val[22:0];
			REG_RADIUS_SECOND: sh_b = val[22:0];
			REG_TILT_DEGREES: sh_tilt = val[8:0];
			default: sh_n = val[10:0];
		endcase
	endtask

	task automatic set_geometry(input logic [23:0] cx, cy, input logic [22:0] a, b,
			input logic [8:0] tilt, input logic [10:0] n);
		write_reg(REG_CENTER_X, cx);
		write_reg(REG_CENTER_Y, cy);
		write_reg(REG_RADIUS_FIRST, {1'b0, a});
		write_reg(REG_RADIUS_SECOND, {1'b0, b});
		write_reg(REG_TILT_DEGREES, {15'd0, tilt});
		write_reg(REG_POINT_COUNT, {13'd0, n});
		cfg_wr_en <= 1'b0;
	endtask

	function automatic int eff_count();
		int n;
		n = (sh_n == 0) ? DEFAULT_POINTS : sh_n;
		return (n > MAX_POINTS) ? MAX_POINTS : n;
	endfunction

	// Mostly in-range indexes, with the closing index and some beyond it.
	task automatic queue_random(input int count);
		int n;
		n = eff_count();
		repeat (count) begin
			case ($urandom_range(0, 9))
				0: pending_idx.push_back(11'(n));
				1: pending_idx.push_back(11'($urandom_range(0, 2047)));
				default: pending_idx.push_back(11'($urandom_range(0, n - 1)));
			endcase
		end
	endtask

	initial begin
		sh_cx = 0; sh_cy = 0; sh_a = 0; sh_b = 0; sh_tilt = 0; sh_n = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset values: zero geometry, default count, closing and beyond indexes.
		foreach (pending_idx[k]) ;
		pending_idx.push_back(11'd0);
		pending_idx.push_back(11'd64);
		pending_idx.push_back(11'd65);
		pending_idx.push_back(11'd2047);
		wait_idle();

		// Extremes: full radii, saturating centres, count above the maximum, tilt past 360.
		set_geometry(24'h7FFFFF, 24'h800000, 23'h7FFFFF, 23'h7FFFFF, 9'd511, 11'd2047);
		pending_idx.push_back(11'd0);
		pending_idx.push_back(11'd256);
		pending_idx.push_back(11'd512);
		pending_idx.push_back(11'd768);
		pending_idx.push_back(11'd1023);
		pending_idx.push_back(11'd1024);
		pending_idx.push_back(11'd1025);
		wait_idle();
		set_geometry(24'h800000, 24'h7FFFFF, 23'd25600, 23'd0, 9'd359, 11'd1);
		pending_idx.push_back(11'd0);
		pending_idx.push_back(11'd1);
		pending_idx.push_back(11'd2);
		wait_idle();
		// Circle with a small count whose vertices step across quadrants, then a tilt of 90.
		set_geometry(24'd0, 24'd0, 23'd2560, 23'd2560, 9'd0, 11'd4);
		for (int k = 0; k <= 5; k++) pending_idx.push_back(11'(k));
		wait_idle();
		set_geometry(24'h001234, 24'hFFF000, 23'd1000, 23'd50000, 9'd90, 11'd1024);
		pending_idx.push_back(11'd1024);
		pending_idx.push_back(11'd1);
		pending_idx.push_back(11'd1365);
		wait_idle();

		// Random phases with fresh geometry each time.
		for (int ph = 0; ph < 10; ph++) begin
			set_geometry(24'($urandom), 24'($urandom),
				(ph % 3 == 0) ? 23'($urandom) : 23'($urandom_range(0, 65535)),
				(ph % 3 == 1) ? 23'($urandom) : 23'($urandom_range(0, 65535)),
				9'($urandom), (ph % 4 == 0) ? 11'($urandom) : 11'($urandom_range(0, 1024)));
			if (ph == 4) begin
				// Hold results off long enough for the queue to fill and stall input.
				long_stall = 200;
			end
			if (ph == 6) begin
				// Let part of the batch go, then pause until every result is back.
				queue_random(60);
				while (pending_idx.size() > 30) @(posedge clk);
				hold_sender = 1'b1;
				while (s_axis_tvalid || expected_vertices.size() > 0) @(posedge clk);
				hold_sender = 1'b0;
			end
			if (ph == 9) calm = 1'b1;
			queue_random(120);
			wait_idle();
		end

		if (mismatches == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
